// ===== hdl/sbpp_pkg.sv =====
// Shared constants for the servo bus packet parser.
// No dependencies.
package sbpp_pkg;

  // parameter buffer capacity in bytes
  localparam int MAX_PARAMS = 32;
  // store address and parameter count widths
  localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int CNT_W = $clog2(MAX_PARAMS + 1);

  // fixed field widths on the ports
  localparam int BYTE_W  = 8;
  localparam int PCOUNT_W = 6;
  localparam int PINDEX_W = 5;
  localparam int TAKEN_W = 6;

  // header byte value
  localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;

  // result data packing
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

endpackage

// ===== hdl/sbpp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sbpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/servo_bus_packet_parser.sv =====
// Top level of the servo bus packet parser: byte framing, checksum and result burst.
// Depends on sbpp_pkg and sbpp_ram.

// Takes one received bus byte per request and parses protocol 1 style frames:
// two 0xFF header bytes, id, length, op byte, length-2 parameter bytes and a
// checksum (inverted 8-bit sum of id, length, op byte and parameters).
// Parameter bytes go into a RAM of MAX_PARAMS bytes. While a frame is being
// parsed one byte is accepted every cycle; the length and checksum bytes wait
// only if the output register is still holding an untaken result. A good
// frame with n parameters is then played out of the RAM as n results, each
// read from the RAM and then loaded into the output register once it is
// free; no bytes are taken during the burst. A good frame with no parameters,
// a bad checksum or a bad length gives a single result with tlast set, the
// last two flagged.
module servo_bus_packet_parser
  import sbpp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input byte stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] packet_id, [15:8] op_byte, [21:16] param_count, [26:22] param_index,
  // [34:27] param_value, [39:35] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [OUT_USER_W-1:0] m_axis_tuser,   // [0] checksum_good, [1] length_bad
  output logic                  m_axis_tlast
);

  // parser phases
  localparam logic [2:0] PH_HDR1  = 3'd0;
  localparam logic [2:0] PH_HDR2  = 3'd1;
  localparam logic [2:0] PH_ID    = 3'd2;
  localparam logic [2:0] PH_LEN   = 3'd3;
  localparam logic [2:0] PH_OP    = 3'd4;
  localparam logic [2:0] PH_PARAM = 3'd5;
  localparam logic [2:0] PH_CHK   = 3'd6;
  localparam logic [2:0] PH_EMIT  = 3'd7;

  logic [2:0]          phase;
  logic [BYTE_W-1:0]   id_seen;
  logic [BYTE_W-1:0]   length_seen;
  logic [BYTE_W-1:0]   op_seen;
  logic [TAKEN_W-1:0]  bytes_taken;
  logic [BYTE_W-1:0]   running_sum;
  logic [CNT_W-1:0]    emit_idx;
  logic                rd_issued;

  // output register
  logic                out_valid;
  logic [BYTE_W-1:0]   out_id;
  logic [BYTE_W-1:0]   out_op;
  logic [PCOUNT_W-1:0] out_count;
  logic [PINDEX_W-1:0] out_index;
  logic [BYTE_W-1:0]   out_value;
  logic                out_good;
  logic                out_lbad;
  logic                out_last;

  logic                out_free;
  logic                out_load;
  logic                in_acc;
  logic                result_phase;
  logic [BYTE_W-1:0]   sum_next;
  logic                sum_match;
  logic [TAKEN_W-1:0]  taken_next;
  logic                params_done;
  logic                length_bad;
  logic [CNT_W-1:0]    param_n;
  logic                emit_last;
  logic                ram_we;
  logic                ram_re;
  logic [BYTE_W-1:0]   ram_rdata;

  // handshake
  assign out_free      = !out_valid || m_axis_tready;
  assign result_phase  = (phase == PH_LEN) || (phase == PH_CHK);
  assign s_axis_tready = (phase != PH_EMIT) && (out_free || !result_phase);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // per-byte datapath
  assign sum_next    = running_sum + s_axis_tdata;
  assign sum_match   = (s_axis_tdata == ~running_sum);
  assign taken_next  = bytes_taken + TAKEN_W'(1);
  assign params_done = ({3'b000, taken_next} + 9'd2) >= {1'b0, length_seen};
  assign length_bad  = (s_axis_tdata < 8'd2) ||
                       ({1'b0, s_axis_tdata} > 9'(MAX_PARAMS + 2));
  assign param_n     = CNT_W'(length_seen - 8'd2);
  assign emit_last   = ({1'b0, emit_idx} + (CNT_W+1)'(1)) == {1'b0, param_n};

  // a new result enters the output register
  assign out_load = (in_acc && (phase == PH_LEN) && length_bad) ||
                    (in_acc && (phase == PH_CHK) && !(sum_match && (param_n != '0))) ||
                    ((phase == PH_EMIT) && rd_issued && out_free);

  // parameter store access
  assign ram_we = in_acc && (phase == PH_PARAM) &&
                  ({1'b0, bytes_taken} < 7'(MAX_PARAMS));
  assign ram_re = (phase == PH_EMIT) && !rd_issued;

  sbpp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PARAMS)
  ) u_param_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bytes_taken[IDX_W-1:0]),
    .wdata (s_axis_tdata),
    .re    (ram_re),
    .raddr (emit_idx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // parser control and frame fields
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR1;
      id_seen     <= '0;
      length_seen <= '0;
      op_seen     <= '0;
      bytes_taken <= '0;
      running_sum <= '0;
      emit_idx    <= '0;
      rd_issued   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // output register occupancy
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (in_acc) begin
        case (phase)
          PH_HDR2: begin
            phase <= (s_axis_tdata == HDR_BYTE) ? PH_ID : PH_HDR1;
          end
          PH_ID: begin
            id_seen     <= s_axis_tdata;
            running_sum <= s_axis_tdata;
            phase       <= PH_LEN;
          end
          PH_LEN: begin
            length_seen <= s_axis_tdata;
            if (length_bad) begin
              op_seen   <= '0;
              phase     <= PH_HDR1;
            end else begin
              running_sum <= sum_next;
              bytes_taken <= '0;
              phase       <= PH_OP;
            end
          end
          PH_OP: begin
            op_seen     <= s_axis_tdata;
            running_sum <= sum_next;
            phase       <= (length_seen > 8'd2) ? PH_PARAM : PH_CHK;
          end
          PH_PARAM: begin
            bytes_taken <= taken_next;
            running_sum <= sum_next;
            if (params_done) begin
              phase <= PH_CHK;
            end
          end
          PH_CHK: begin
            if (sum_match && (param_n != '0)) begin
              phase     <= PH_EMIT;
              emit_idx  <= '0;
              rd_issued <= 1'b0;
            end else begin
              phase     <= PH_HDR1;
            end
          end
          default: begin
            phase <= (s_axis_tdata == HDR_BYTE) ? PH_HDR2 : PH_HDR1;
          end
        endcase
      end
      // parameter burst: read one entry, then load it into the output register
      if (phase == PH_EMIT) begin
        if (!rd_issued) begin
          rd_issued <= 1'b1;
        end else if (out_free) begin
          rd_issued <= 1'b0;
          emit_idx  <= emit_idx + CNT_W'(1);
          if (emit_last) begin
            phase <= PH_HDR1;
          end
        end
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_acc && (phase == PH_LEN) && length_bad) begin
      out_id    <= id_seen;
      out_op    <= '0;
      out_count <= '0;
      out_index <= '0;
      out_value <= '0;
      out_good  <= 1'b0;
      out_lbad  <= 1'b1;
      out_last  <= 1'b1;
    end else if (in_acc && (phase == PH_CHK)) begin
      out_id    <= id_seen;
      out_op    <= op_seen;
      out_count <= PCOUNT_W'(param_n);
      out_index <= '0;
      out_value <= '0;
      out_good  <= sum_match;
      out_lbad  <= 1'b0;
      out_last  <= 1'b1;
    end else if ((phase == PH_EMIT) && rd_issued && out_free) begin
      out_id    <= id_seen;
      out_op    <= op_seen;
      out_count <= PCOUNT_W'(param_n);
      out_index <= PINDEX_W'(emit_idx);
      out_value <= ram_rdata;
      out_good  <= 1'b1;
      out_lbad  <= 1'b0;
      out_last  <= emit_last;
    end
  end

  // port packing
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b00000, out_value, out_index, out_count, out_op, out_id};
  assign m_axis_tuser  = {out_lbad, out_good};
  assign m_axis_tlast  = out_last;

endmodule

// ===== hdl/sbpp_checker.sv =====
// Port-level checks for the servo bus packet parser, bound to the top level.
// Depends on sbpp_pkg.
module sbpp_port_checks
  import sbpp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [BYTE_W-1:0]     s_axis_tdata,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser,
  input logic                  m_axis_tlast
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  // a length error is a lone result with no op byte or count
  a_lbad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |->
      m_axis_tlast && !m_axis_tuser[0] && (m_axis_tdata[21:8] == 14'd0))
    else $error("length error result malformed");

  // any failed frame ends in its single result
  a_bad_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata[34:22] == 13'd0))
    else $error("failed frame result not single");

  // a frame without parameters gives one result carrying no parameter
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[21:16] == 6'd0) |->
      m_axis_tlast && (m_axis_tdata[34:22] == 13'd0))
    else $error("empty frame result malformed");

  // no byte is taken while a parameter burst is still playing out
  a_burst_gap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] && !m_axis_tlast |-> !s_axis_tready)
    else $error("byte accepted during parameter burst");

endmodule

bind servo_bus_packet_parser sbpp_port_checks u_sbpp_port_checks (.*);
